// ----- sv/assert_macros.svh -----
// Assertion macros for the RTL, included by the datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define XSS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define XSS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- sv/xss_pkg.sv -----
// Package: constants, command types and reset seeding for the xoshiro256** source.
package xss_pkg;

  localparam logic [63:0] GOLDEN_STEP = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MIX_MUL_A   = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MIX_MUL_B   = 64'h94D0_49BB_1331_11EB;

  localparam int          COORD_W     = 21;
  localparam int          SUM_W       = COORD_W + 2;
  localparam logic [SUM_W-1:0] COORD_MAX = SUM_W'((1 << COORD_W) - 1);

  localparam int          OUT_COUNT_W   = 32;
  localparam int          COUNT_W_DEF   = 32;
  localparam int          PADDR_W       = 4;
  localparam int          PDATA_W       = 64;

  // splitmix64 finalizer on an already advanced accumulator
  function automatic logic [63:0] mix_fin(input logic [63:0] acc);
    logic [63:0] z;
    z = acc;
    z = (z ^ (z >> 30)) * MIX_MUL_A;
    z = (z ^ (z >> 27)) * MIX_MUL_B;
    return z ^ (z >> 31);
  endfunction

  // Generator state for seed zero, loaded at reset
  localparam logic [63:0] SEED0_V0 = mix_fin(GOLDEN_STEP);
  localparam logic [63:0] SEED0_V1 = mix_fin(64'(GOLDEN_STEP + GOLDEN_STEP));
  localparam logic [63:0] RST_W0   = {32'h0, SEED0_V0[31:0]};
  localparam logic [63:0] RST_W1   = {32'h0, SEED0_V0[63:32]};
  localparam logic [63:0] RST_W2   = {32'h0, SEED0_V1[31:0]};
  localparam logic [63:0] RST_W3   = {32'h0, SEED0_V1[63:32]};

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_XA,
    ST_MA0,
    ST_MA1,
    ST_MA2,
    ST_XB,
    ST_MB0,
    ST_MB1,
    ST_MB2,
    ST_STORE,
    ST_FINISH
  } xss_state_t;

  // Datapath operations
  typedef enum logic [2:0] {
    OP_NONE,
    OP_DRAW,
    OP_LOAD,
    OP_XORA,
    OP_XORB,
    OP_MUL,
    OP_STORE,
    OP_RESTART_OUT
  } xss_op_t;

  // Partial product selects for the 64x64 low-half multiply
  typedef enum logic [1:0] {
    MP_LO_LO,
    MP_LO_HI,
    MP_HI_LO
  } xss_mpart_t;

  typedef struct packed {
    xss_op_t    op;
    xss_mpart_t mpart;
    logic       use_b;
    logic       second;
  } xss_cmd_t;

  typedef struct packed {
    logic out_free;
  } xss_status_t;

  // Register byte offsets (one 64-bit register per 8 bytes)
  localparam logic [PADDR_W-1:0] REG_SEED = PADDR_W'(0);

endpackage

// ----- sv/xss_cfg.sv -----
// APB-style configuration register block holding the seed.
module xss_cfg
  import xss_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic [63:0]        seed
);

  logic [63:0] seed_r;
  logic        wr_en;
  logic        sel_seed;

  // only the register index bit decodes; byte offset bits are ignored
  assign sel_seed = (paddr[PADDR_W-1:3] == REG_SEED[PADDR_W-1:3]);
  assign wr_en    = psel && penable && pwrite && pready;
  assign pready   = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (wr_en && sel_seed) begin
      seed_r <= pwdata;
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    if (sel_seed) begin
      prdata = seed_r;
    end
  end

  assign seed = seed_r;

endmodule

// ----- sv/xss_ctrl.sv -----
// Controller: accepts words, sequences the splitmix64 reseed, issues datapath commands.
module xss_ctrl
  import xss_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_restart,
  output logic        in_stall,
  input  xss_status_t status,
  output xss_cmd_t    cmd
);

  xss_state_t state_r, state_nxt;
  logic       pass_r, pass_nxt;
  logic       take;

  assign take     = (state_r == ST_IDLE) && status.out_free && in_valid;
  assign in_stall = !((state_r == ST_IDLE) && status.out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pass_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pass_r  <= pass_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    pass_nxt  = pass_r;
    case (state_r)
      ST_IDLE: begin
        if (take && in_restart) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        pass_nxt  = 1'b0;
        state_nxt = ST_XA;
      end
      ST_XA:  state_nxt = ST_MA0;
      ST_MA0: state_nxt = ST_MA1;
      ST_MA1: state_nxt = ST_MA2;
      ST_MA2: state_nxt = ST_XB;
      ST_XB:  state_nxt = ST_MB0;
      ST_MB0: state_nxt = ST_MB1;
      ST_MB1: state_nxt = ST_MB2;
      ST_MB2: state_nxt = ST_STORE;
      ST_STORE: begin
        pass_nxt  = 1'b1;
        state_nxt = pass_r ? ST_FINISH : ST_XA;
      end
      ST_FINISH: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd        = '0;
    cmd.op     = OP_NONE;
    cmd.mpart  = MP_LO_LO;
    cmd.second = pass_r;
    case (state_r)
      ST_IDLE: begin
        if (take && !in_restart) begin
          cmd.op = OP_DRAW;
        end
      end
      ST_LOAD:  cmd.op = OP_LOAD;
      ST_XA:    cmd.op = OP_XORA;
      ST_MA0: begin
        cmd.op    = OP_MUL;
        cmd.mpart = MP_LO_LO;
      end
      ST_MA1: begin
        cmd.op    = OP_MUL;
        cmd.mpart = MP_LO_HI;
      end
      ST_MA2: begin
        cmd.op    = OP_MUL;
        cmd.mpart = MP_HI_LO;
      end
      ST_XB:    cmd.op = OP_XORB;
      ST_MB0: begin
        cmd.op    = OP_MUL;
        cmd.mpart = MP_LO_LO;
        cmd.use_b = 1'b1;
      end
      ST_MB1: begin
        cmd.op    = OP_MUL;
        cmd.mpart = MP_LO_HI;
        cmd.use_b = 1'b1;
      end
      ST_MB2: begin
        cmd.op    = OP_MUL;
        cmd.mpart = MP_HI_LO;
        cmd.use_b = 1'b1;
      end
      ST_STORE: cmd.op = OP_STORE;
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.op = OP_RESTART_OUT;
        end
      end
      default: cmd.op = OP_NONE;
    endcase
  end

endmodule

// ----- sv/xss_dp.sv -----
// Datapath: generator words, splitmix64 multiply-accumulate, hit counter, output register.
`include "assert_macros.svh"

module xss_dp
  import xss_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_W_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [63:0]            seed,
  input  xss_cmd_t               cmd,
  output xss_status_t            status,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [63:0]            out_random_word,
  output logic                   out_hit,
  output logic [OUT_COUNT_W-1:0] out_hit_count
);

  logic [63:0]            w_r [4];
  logic [63:0]            acc_r;
  logic [63:0]            z_r;
  logic [63:0]            p_r;
  logic [COUNT_WIDTH-1:0] hits_r, hits_nxt;
  logic                   out_valid_r;
  logic [63:0]            out_word_r;
  logic                   out_hit_r;
  logic [OUT_COUNT_W-1:0] out_count_r;

  logic [63:0]      mconst;
  logic [31:0]      mul_a, mul_b;
  logic [63:0]      prod;
  logic [63:0]      mix_out;
  logic [63:0]      t5, r7, draw_word, sh17;
  logic [63:0]      n0, n1, n2, n3;
  logic [SUM_W-1:0] coord_sum;
  logic             draw_hit;
  logic [OUT_COUNT_W-1:0] count_sat;
  logic             load_out;

  assign status.out_free = !out_valid_r || !out_stall;
  assign load_out = (cmd.op == OP_DRAW) || (cmd.op == OP_RESTART_OUT);

  // one 32x32 partial product per cycle of the 64-bit low-half multiply
  assign mconst = cmd.use_b ? MIX_MUL_B : MIX_MUL_A;
  always_comb begin
    case (cmd.mpart)
      MP_LO_LO: begin
        mul_a = z_r[31:0];
        mul_b = mconst[31:0];
      end
      MP_LO_HI: begin
        mul_a = z_r[31:0];
        mul_b = mconst[63:32];
      end
      MP_HI_LO: begin
        mul_a = z_r[63:32];
        mul_b = mconst[31:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign prod    = 64'(mul_a) * 64'(mul_b);
  assign mix_out = p_r ^ (p_r >> 31);

  // xoshiro256** output and state update
  assign t5        = w_r[1] + (w_r[1] << 2);
  assign r7        = {t5[56:0], t5[63:57]};
  assign draw_word = r7 + (r7 << 3);
  assign sh17      = w_r[1] << 17;
  assign n2        = w_r[2] ^ w_r[0];
  assign n3        = w_r[3] ^ w_r[1];
  assign n1        = w_r[1] ^ n2;
  assign n0        = w_r[0] ^ n3;

  // hit test on the three 21-bit coordinates
  assign coord_sum = SUM_W'(draw_word[20:0]) + SUM_W'(draw_word[41:21])
                   + SUM_W'(draw_word[62:42]);
  assign draw_hit  = (coord_sum < COORD_MAX);

  always_comb begin
    hits_nxt = hits_r;
    if (draw_hit && (hits_r != '1)) begin
      hits_nxt = hits_r + COUNT_WIDTH'(1);
    end
  end

  // clamp the counter to the 32-bit result field
  generate
    if (COUNT_WIDTH > OUT_COUNT_W) begin : g_wide
      assign count_sat = (|hits_nxt[COUNT_WIDTH-1:OUT_COUNT_W]) ? '1
                         : hits_nxt[OUT_COUNT_W-1:0];
    end else begin : g_narrow
      assign count_sat = OUT_COUNT_W'(hits_nxt);
    end
  endgenerate

  // generator words and hit counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r[0] <= RST_W0;
      w_r[1] <= RST_W1;
      w_r[2] <= RST_W2;
      w_r[3] <= RST_W3;
      hits_r <= '0;
    end else begin
      case (cmd.op)
        OP_DRAW: begin
          w_r[0] <= n0;
          w_r[1] <= n1;
          w_r[2] <= n2 ^ sh17;
          w_r[3] <= {n3[18:0], n3[63:19]};
          hits_r <= hits_nxt;
        end
        OP_STORE: begin
          if (cmd.second) begin
            w_r[2] <= {32'h0, mix_out[31:0]};
            w_r[3] <= {32'h0, mix_out[63:32]};
          end else begin
            w_r[0] <= {32'h0, mix_out[31:0]};
            w_r[1] <= {32'h0, mix_out[63:32]};
          end
        end
        OP_RESTART_OUT: hits_r <= '0;
        default: ;
      endcase
    end
  end

  // splitmix64 working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD:  acc_r <= seed + GOLDEN_STEP;
      OP_XORA:  z_r   <= acc_r ^ (acc_r >> 30);
      OP_XORB:  z_r   <= p_r ^ (p_r >> 27);
      OP_MUL: begin
        if (cmd.mpart == MP_LO_LO) begin
          p_r <= prod;
        end else begin
          p_r <= p_r + {prod[31:0], 32'h0};
        end
      end
      OP_STORE: acc_r <= acc_r + GOLDEN_STEP;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_DRAW) begin
      out_word_r  <= draw_word;
      out_hit_r   <= draw_hit;
      out_count_r <= count_sat;
    end else if (cmd.op == OP_RESTART_OUT) begin
      out_word_r  <= '0;
      out_hit_r   <= 1'b0;
      out_count_r <= '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_random_word = out_word_r;
  assign out_hit         = out_hit_r;
  assign out_hit_count   = out_count_r;

  // checks
  `XSS_ASSERT(a_load_when_free, load_out |-> status.out_free, "result loaded over a held word")
  `XSS_ASSERT(a_restart_zero, (cmd.op == OP_RESTART_OUT) |=> (out_hit_count == '0 && out_random_word == '0 && hits_r == '0), "restart result or counter not cleared")
  `XSS_ASSERT(a_count_monotonic, (cmd.op == OP_DRAW) |=> (hits_r >= $past(hits_r)), "hit counter went down on a draw")
  `XSS_ASSERT(a_hit_counted, (out_valid && out_hit) |-> (out_hit_count != '0), "hit reported with zero count")

endmodule

// ----- sv/xoshiro256ss_random_source_unit.sv -----
// Top level of the xoshiro256** random source with splitmix64 reseeding.
//
// Input channel (in_valid / in_stall / in_restart): each word is one draw
// (in_restart = 0) or one reseed (in_restart = 1). Result channel (out_valid /
// out_stall): one word per input word with the 64-bit output, the hit flag of
// the three 21-bit coordinates and the saturating hit count.
// A draw is computed in the cycle it is accepted and is registered at that
// edge: one draw per cycle while the receiver takes results.
// A reseed runs two splitmix64 steps on one shared 32x32 multiplier, three
// partial products per 64-bit multiply: the zero result is presented after
// the second step is stored (later if the previous result is still held), and
// no word is accepted in the meantime.
// The seed is written through the APB port and is used at the next reseed.
// Reset (rst_n low, synchronous) clears the seed and hit count and loads the
// generator with the state seeded from zero, so draws can start at once.
// When the receiver stalls, the held result stays put and in_stall stays high
// until it is taken.
module xoshiro256ss_random_source_unit
  import xss_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_W_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_restart,
  // result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [63:0]            out_random_word,
  output logic                   out_hit,
  output logic [OUT_COUNT_W-1:0] out_hit_count,
  // configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_W-1:0]     paddr,
  input  logic [PDATA_W-1:0]     pwdata,
  output logic [PDATA_W-1:0]     prdata,
  output logic                   pready
);

  logic [63:0] seed;
  xss_cmd_t    cmd;
  xss_status_t status;

  xss_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .seed    (seed)
  );

  xss_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_restart (in_restart),
    .in_stall   (in_stall),
    .status     (status),
    .cmd        (cmd)
  );

  xss_dp #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .seed            (seed),
    .cmd             (cmd),
    .status          (status),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_random_word (out_random_word),
    .out_hit         (out_hit),
    .out_hit_count   (out_hit_count)
  );

endmodule
